// ----- rtl/uer_pkg.sv -----
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by every module of the block.
package uer_pkg;

    // Default width of the tick counter
    localparam int unsigned COUNTER_WIDTH_DEF = 17;

    // Configuration register indexes and reset values
    localparam logic [1:0] REG_RISE_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_HIGH_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_MIN_DISTANCE = 2'd2;

    localparam logic [15:0] RISE_TIMEOUT_RST = 16'd2200;
    localparam logic [15:0] HIGH_TIMEOUT_RST = 16'd4500;
    localparam logic [7:0]  MIN_DISTANCE_RST = 8'd2;

    // Final count never exceeds high_timeout + 1, so 17 bits always hold it
    localparam int unsigned FCOUNT_W = 17;
    localparam int unsigned DIST_W   = 14;

    // Distance = floor(count * 17 / 100) = floor(floor(count * 17 / 4) / 25);
    // the divide by 25 is a multiply by ceil(2^24 / 25) and a shift by 24
    localparam int unsigned SCALED_W  = 20;
    localparam int unsigned RECIP_SH  = 24;
    localparam logic [19:0] RECIP_25  = 20'd671089;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 24;

    // Measurement phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_RISE = 3'b010,
        PH_HIGH = 3'b100
    } t_phase;

    // Result of the state stage, handed to the distance stage
    typedef struct packed {
        logic                trigger_one;
        logic                trigger_two;
        logic                busy;
        logic                done;
        logic [FCOUNT_W-1:0] count;
    } t_core_res;

endpackage

// ----- rtl/uer_core.sv -----
// Measurement state machine: trigger, wait for echo rise, count echo high.
// Depends on uer_pkg.
module uer_core #(
    parameter int unsigned COUNTER_WIDTH = uer_pkg::COUNTER_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,          // stage may load
    input  logic              i_valid,       // a transaction waits in the input register
    input  logic              i_start_req,
    input  logic              i_sensor_select,
    input  logic              i_echo_one,
    input  logic              i_echo_two,
    input  logic [15:0]       i_rise_timeout,
    input  logic [15:0]       i_high_timeout,
    output logic              o_valid,
    output uer_pkg::t_core_res o_res
);
    import uer_pkg::*;

    localparam int unsigned CMP_W = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;

    t_phase                   r_phase, n_phase;
    logic [COUNTER_WIDTH-1:0] r_count, n_count;
    logic                     r_chosen, n_chosen;
    logic                     r_valid;
    t_core_res                r_res, n_res;

    logic                     echo;
    logic [COUNTER_WIDTH-1:0] count_up;
    logic [COUNTER_WIDTH-1:0] final_count;
    logic                     finish;

    assign echo     = r_chosen ? i_echo_two : i_echo_one;
    // saturating increment
    assign count_up = (r_count == '1) ? r_count : r_count + COUNTER_WIDTH'(1);

    // Next state and result for one tick
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_chosen    = r_chosen;
        finish      = 1'b0;
        final_count = '0;
        n_res       = '0;
        case (r_phase)
            PH_RISE: begin
                if (echo) begin
                    n_count = COUNTER_WIDTH'(1);
                    n_phase = PH_HIGH;
                    if (CMP_W'(n_count) > CMP_W'(i_high_timeout)) begin
                        finish      = 1'b1;
                        final_count = n_count;
                    end
                end else begin
                    n_count = count_up;
                    if (CMP_W'(n_count) > CMP_W'(i_rise_timeout)) begin
                        finish = 1'b1;
                    end
                end
            end
            PH_HIGH: begin
                if (echo) begin
                    n_count = count_up;
                    if (CMP_W'(n_count) > CMP_W'(i_high_timeout)) begin
                        finish      = 1'b1;
                        final_count = n_count;
                    end
                end else begin
                    finish      = 1'b1;
                    final_count = r_count;
                end
            end
            default: begin
                // idle, and any stray code behaves as idle
                n_phase = PH_IDLE;
                if (i_start_req) begin
                    n_chosen          = i_sensor_select;
                    n_res.trigger_two = i_sensor_select;
                    n_res.trigger_one = !i_sensor_select;
                    n_count           = '0;
                    n_phase           = PH_RISE;
                end
            end
        endcase

        if (finish) begin
            n_res.done  = 1'b1;
            n_res.count = FCOUNT_W'(final_count);
            n_phase     = PH_IDLE;
            n_count     = '0;
        end else if (n_phase != PH_IDLE) begin
            n_res.busy = 1'b1;
        end
    end

    // State and result registers, advanced once per consumed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_count  <= '0;
            r_chosen <= 1'b0;
            r_valid  <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_phase  <= n_phase;
                r_count  <= n_count;
                r_chosen <= n_chosen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- rtl/uer_dist.sv -----
// Distance stage: count to centimeters, short-range clamp, output register.
// Depends on uer_pkg.
module uer_dist (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  uer_pkg::t_core_res                 i_res,
    input  logic [7:0]                         i_min_distance,
    output logic                               o_valid,
    output logic [uer_pkg::OUT_DATA_W-1:0]     o_data
);
    import uer_pkg::*;

    logic [FCOUNT_W+4:0]          times17;
    logic [SCALED_W-1:0]          quarter;
    logic [SCALED_W+19:0]         product;
    logic [DIST_W-1:0]            quotient;
    logic [DIST_W-1:0]            dist_val;
    logic                         r_valid;
    logic [OUT_DATA_W-1:0]        r_data;
    logic [OUT_DATA_W-1:0]        n_data;

    // count * 17, then / 4, then / 25 by reciprocal
    assign times17  = (FCOUNT_W + 5)'({i_res.count, 4'b0000})
                    + (FCOUNT_W + 5)'(i_res.count);
    assign quarter  = SCALED_W'(times17 >> 2);
    assign product  = (SCALED_W + 20)'(quarter) * (SCALED_W + 20)'(RECIP_25);
    assign quotient = DIST_W'(product >> RECIP_SH);

    always_comb begin
        dist_val = '0;
        if (i_res.done) begin
            dist_val = ((DIST_W + 1)'(quotient) <= (DIST_W + 1)'(i_min_distance))
                     ? DIST_W'(1) : quotient;
        end
        n_data = {6'b0, dist_val, i_res.done, i_res.busy, i_res.trigger_two,
                  i_res.trigger_one};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/ultrasonic_echo_ranger_top.sv -----
// Two-sensor ultrasonic echo ranger. Each input transaction is one 10 us tick
// and yields exactly one output transaction. The block takes one tick per clock
// cycle while the output does not stall. An input register, the state
// stage (trigger, rise wait, high count) and the distance stage (one 20x20
// multiply and the short-range clamp) each hold one tick. Back-pressure on the
// output stalls the stages in turn, so s_tready drops only when all three are
// full. Configuration writes take effect at once and are meant for idle times.
// Depends on uer_pkg, uer_core and uer_dist.
module ultrasonic_echo_ranger_top #(
    parameter int unsigned COUNTER_WIDTH = uer_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] start_req [1] sensor_select [2] echo_one [3] echo_two [7:4] zero
    input  logic [uer_pkg::IN_DATA_W-1:0]   s_tdata,
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] trigger_one [1] trigger_two [2] busy_res [3] done_res
    // [17:4] distance_cm [23:18] zero
    output logic [uer_pkg::OUT_DATA_W-1:0]  m_tdata,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_addr,
    input  logic [15:0]                     i_cfg_wdata
);
    import uer_pkg::*;

    logic [15:0]          r_rise_timeout;
    logic [15:0]          r_high_timeout;
    logic [7:0]           r_min_distance;
    logic                 r_in_valid;
    logic [IN_DATA_W-1:0] r_in_data;
    logic                 out_en, mid_en;
    logic                 mid_valid;
    t_core_res            mid_res;

    // Stage enables: a stage loads when it is empty or its contents move on
    assign out_en   = !m_tvalid || m_tready;
    assign mid_en   = !mid_valid || out_en;
    assign s_tready = !r_in_valid || mid_en;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_timeout <= RISE_TIMEOUT_RST;
            r_high_timeout <= HIGH_TIMEOUT_RST;
            r_min_distance <= MIN_DISTANCE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_RISE_TIMEOUT: r_rise_timeout <= i_cfg_wdata;
                REG_HIGH_TIMEOUT: r_high_timeout <= i_cfg_wdata;
                REG_MIN_DISTANCE: r_min_distance <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_data <= s_tdata;
        end
    end

    uer_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (mid_en),
        .i_valid         (r_in_valid),
        .i_start_req     (r_in_data[0]),
        .i_sensor_select (r_in_data[1]),
        .i_echo_one      (r_in_data[2]),
        .i_echo_two      (r_in_data[3]),
        .i_rise_timeout  (r_rise_timeout),
        .i_high_timeout  (r_high_timeout),
        .o_valid         (mid_valid),
        .o_res           (mid_res)
    );

    uer_dist u_dist (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (out_en),
        .i_valid        (mid_valid),
        .i_res          (mid_res),
        .i_min_distance (r_min_distance),
        .o_valid        (m_tvalid),
        .o_data         (m_tdata)
    );

    // Both triggers never fire on the same tick
    a_one_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("both triggers driven in one tick");

    // Distance is zero except on the done tick
    a_dist_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tdata[3]) |-> (m_tdata[17:4] == 14'd0))
        else $error("distance present without done");

    // Done and busy are exclusive
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tdata[3] && m_tdata[2]))
        else $error("done and busy together");

    // Pipeline is empty and ready right after reset
    a_ready_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (s_tready && !m_tvalid))
        else $error("not ready after reset");

endmodule

// ----- tb/sv/ranging_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the ultrasonic echo ranger: a tick-by-tick predictor plus result checks.
// Depends on uer_pkg for the phase encoding, register indexes and reset values.
package ranging_tb_pkg;

    import uer_pkg::*;

    localparam int unsigned TICK_W = COUNTER_WIDTH_DEF;

    // One output transaction as the ranger should produce it
    typedef struct packed {
        logic        trig_one;
        logic        trig_two;
        logic        busy;
        logic        done;
        logic [13:0] dist_cm;
    } t_tick_result;

    class ranging_scoreboard;

        logic [15:0]       rise_timeout;
        logic [15:0]       high_timeout;
        logic [7:0]        min_cm;
        t_phase            phase;
        logic [TICK_W-1:0] ticks;
        bit                chosen;
        t_tick_result      awaited_results[$];
        int unsigned       errors;

        function new();
            rise_timeout = RISE_TIMEOUT_RST;
            high_timeout = HIGH_TIMEOUT_RST;
            min_cm       = MIN_DISTANCE_RST;
            phase        = PH_IDLE;
            ticks        = '0;
            chosen       = 1'b0;
            errors       = 0;
        endfunction

        function void report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                REG_RISE_TIMEOUT: rise_timeout = value;
                REG_HIGH_TIMEOUT: high_timeout = value;
                REG_MIN_DISTANCE: min_cm = value[7:0];
                default: ;
            endcase
        endfunction

        // Count saturates at the top of the counter
        function logic [TICK_W-1:0] bump(logic [TICK_W-1:0] count);
            return (count == '1) ? count : count + 1'b1;
        endfunction

        // floor(count * 17 / 100), clamped, short range reported as 1 cm
        function logic [13:0] to_cm(logic [TICK_W-1:0] count);
            logic [63:0] cm;
            cm = (64'(count) * 64'd17) / 64'd100;
            if (cm > 64'd16383) cm = 64'd16383;
            if (cm <= 64'(min_cm)) cm = 64'd1;
            return cm[13:0];
        endfunction

        // Advance the ranger by one accepted tick and queue the result it yields
        function void take_tick(bit start, bit sel, bit echo_one, bit echo_two);
            t_tick_result      res;
            bit                echo;
            bit                finish;
            logic [TICK_W-1:0] final_count;
            res         = '0;
            finish      = 1'b0;
            final_count = '0;
            echo        = chosen ? echo_two : echo_one;
            case (phase)
                PH_RISE: begin
                    if (echo) begin
                        // this tick already counts as high
                        ticks = TICK_W'(1);
                        phase = PH_HIGH;
                        if (ticks > high_timeout) begin
                            finish      = 1'b1;
                            final_count = ticks;
                        end
                    end else begin
                        ticks = bump(ticks);
                        if (ticks > rise_timeout) begin
                            finish      = 1'b1;
                            final_count = '0;
                        end
                    end
                end
                PH_HIGH: begin
                    if (echo) begin
                        ticks = bump(ticks);
                        if (ticks > high_timeout) begin
                            finish      = 1'b1;
                            final_count = ticks;
                        end
                    end else begin
                        finish      = 1'b1;
                        final_count = ticks;
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    if (start) begin
                        chosen       = sel;
                        res.trig_one = !sel;
                        res.trig_two = sel;
                        ticks        = '0;
                        phase        = PH_RISE;
                    end
                end
            endcase
            if (finish) begin
                res.done    = 1'b1;
                res.dist_cm = to_cm(final_count);
                phase       = PH_IDLE;
                ticks       = '0;
            end else if (phase != PH_IDLE) begin
                res.busy = 1'b1;
            end
            awaited_results.push_back(res);
        endfunction

        // Compare one output transaction with the oldest prediction
        function void check_result(logic [23:0] word);
            t_tick_result want;
            if (awaited_results.size() == 0) begin
                report($sformatf("result %h with no tick outstanding", word));
                return;
            end
            want = awaited_results.pop_front();
            if (word[0] !== want.trig_one)
                report($sformatf("trigger_one got %b want %b", word[0], want.trig_one));
            if (word[1] !== want.trig_two)
                report($sformatf("trigger_two got %b want %b", word[1], want.trig_two));
            if (word[2] !== want.busy)
                report($sformatf("busy_res got %b want %b", word[2], want.busy));
            if (word[3] !== want.done)
                report($sformatf("done_res got %b want %b", word[3], want.done));
            if (word[17:4] !== want.dist_cm)
                report($sformatf("distance_cm got %0d want %0d", word[17:4], want.dist_cm));
            if (word[23:18] !== 6'd0)
                report($sformatf("pad bits got %b", word[23:18]));
        endfunction

    endclass

endpackage

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Top-level testbench for ultrasonic_echo_ranger_top: drives ticks and config writes,
// checks every output transaction. Depends on uer_pkg and ranging_tb_pkg.
module tb;

    import uer_pkg::*;
    import ranging_tb_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // [0] start_req [1] sensor_select [2] echo_one [3] echo_two [7:4] zero
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // [0] trigger_one [1] trigger_two [2] busy_res [3] done_res [17:4] distance_cm
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_addr;
    logic [15:0]           i_cfg_wdata;

    ranging_scoreboard sb;
    int                src_idle_pct;
    int                snk_idle_pct;
    int                ticks_sent;
    int                stall_cycles;

    ultrasonic_echo_ranger_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        m_tready <= (int'($urandom_range(99)) >= snk_idle_pct);
    end

    // Transaction monitor on both streams
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready)
                sb.take_tick(s_tdata[0], s_tdata[1], s_tdata[2], s_tdata[3]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Watchdog: cycles without any transaction or register write
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("ultrasonic_echo_ranger_top: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // One tick on the input stream, with random sender gaps
    task automatic send_tick(input bit start, input bit sel, input bit echo_one,
                             input bit echo_two);
        while (int'($urandom_range(99)) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, echo_two, echo_one, sel, start};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        ticks_sent++;
    endtask

    // Tick during a measurement: chosen echo at the given level, the rest random
    task automatic busy_tick(input bit sel, input bit level);
        bit other;
        bit start;
        other = 1'($urandom_range(1));
        start = ($urandom_range(7) == 0);
        if (sel)
            send_tick(start, 1'($urandom_range(1)), other, level);
        else
            send_tick(start, 1'($urandom_range(1)), level, other);
    endtask

    // Start, low wait, high pulse, falling tick
    task automatic run_measurement(input int pre_ticks, input int high_ticks);
        bit sel;
        sel = 1'($urandom_range(1));
        send_tick(1'b1, sel, 1'($urandom_range(1)), 1'($urandom_range(1)));
        repeat (pre_ticks) busy_tick(sel, 1'b0);
        repeat (high_ticks) busy_tick(sel, 1'b1);
        busy_tick(sel, 1'b0);
    endtask

    task automatic random_ticks(input int count);
        int stop_at;
        int pre_cap;
        int high_cap;
        stop_at = ticks_sent + count;
        while (ticks_sent < stop_at) begin
            pre_cap  = (sb.rise_timeout < 38) ? int'(sb.rise_timeout) + 2 : 40;
            high_cap = ($urandom_range(9) == 0) ? 600 : 40;
            if (high_cap > int'(sb.high_timeout) + 2)
                high_cap = int'(sb.high_timeout) + 2;
            if ($urandom_range(4) == 0) begin
                // loose ticks between measurements
                repeat ($urandom_range(4, 1))
                    send_tick($urandom_range(3) == 0, 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                run_measurement(int'($urandom_range(pre_cap)),
                                int'($urandom_range(high_cap, 1)));
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
    endtask

    // Drain all results, let the pipeline settle, then write all three registers
    task automatic configure(input logic [15:0] rise, input logic [15:0] high,
                             input logic [7:0] min_cm);
        s_tvalid <= 1'b0;
        // let the monitor note the last accepted tick before polling
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_RISE_TIMEOUT, rise);
        write_reg(REG_HIGH_TIMEOUT, high);
        write_reg(REG_MIN_DISTANCE, {8'b0, min_cm});
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int mode;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = '0;
        i_cfg_wdata  = '0;
        i_rst_n      = 1'b0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        ticks_sent   = 0;
        stall_cycles = 0;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle ticks, echoes toggling with nothing running
        send_tick(1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1, 1'b1);
        configure(16'd2, 16'd3, 8'd0);
        // Sensor one never echoes: rise timeout, start on the finishing tick ignored
        send_tick(1'b1, 1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b1);
        // Sensor two: start held while busy, echo stays high until high timeout
        send_tick(1'b1, 1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b1, 1'b0, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0, 1'b1);
        // One-tick pulse on sensor one, clamped to 1 cm
        send_tick(1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0, 1'b1);
        configure(16'd0, 16'd0, 8'd255);
        // Zero timeouts: immediate rise timeout, then immediate high timeout
        send_tick(1'b1, 1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1, 1'b0);

        // Random traffic under three idling patterns and several settings
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    src_idle_pct = 6;
                    snk_idle_pct = 61;
                end
                1: begin
                    src_idle_pct = 61;
                    snk_idle_pct = 6;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            configure(RISE_TIMEOUT_RST, HIGH_TIMEOUT_RST, MIN_DISTANCE_RST);
            random_ticks(150);
            configure(16'($urandom_range(40)), 16'($urandom_range(60)),
                      8'($urandom_range(8)));
            random_ticks(150);
            configure(16'hFFFF, 16'hFFFF, 8'hFF);
            random_ticks(140);
        end
        // Longer pulse that ends on the high timeout, distance well above the floor
        configure(16'd20, 16'd150, 8'd0);
        run_measurement(3, 200);

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ultrasonic_echo_ranger_top: match");
        else
            $display("ultrasonic_echo_ranger_top: mismatch");
        $finish;
    end

endmodule
